// ----- rtl/core/greedy_gated_nearest_match_top_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros for the nearest match block
// ----------------------------------------------------------------------------
`ifndef GREEDY_GATED_NEAREST_MATCH_TOP_MACROS_SVH
`define GREEDY_GATED_NEAREST_MATCH_TOP_MACROS_SVH

// same-cycle implication, disabled in reset
`define GGNM_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define GGNM_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/ggnm_pkg.sv -----
// ----------------------------------------------------------------------------
// ggnm_pkg
// types and codes shared by the nearest match block and its checker
// ----------------------------------------------------------------------------
package ggnm_pkg;

  localparam int POS_W     = 20;
  localparam int GATE_W    = 19;
  localparam int MAG_W     = 21;
  localparam int TRK_W     = 6;
  localparam int DET_W     = 8;
  localparam int CFG_IDX_W = 2;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 16;

  localparam logic [GATE_W-1:0] GATE_RESET = GATE_W'(256);
  localparam logic [DET_W-1:0]  DET_MAX    = '1;

  // request codes on s_tuser
  localparam logic [1:0] REQ_LOAD   = 2'd0;
  localparam logic [1:0] REQ_DETECT = 2'd1;
  localparam logic [1:0] REQ_FINISH = 2'd2;

  // result codes on m_tuser
  localparam logic [1:0] KIND_MATCH      = 2'd0;
  localparam logic [1:0] KIND_UNMATCHED  = 2'd1;
  localparam logic [1:0] KIND_UNASSIGNED = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_X_GATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_GATE = 2'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_FINISH
  } state_t;

endpackage

// ----- rtl/core/ggnm_ram.sv -----
// ----------------------------------------------------------------------------
// ggnm_ram
// simple dual port ram, one write port and one registered read port
// ----------------------------------------------------------------------------
module ggnm_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 32
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic                                     rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/core/greedy_gated_nearest_match_top.sv -----
// ----------------------------------------------------------------------------
// greedy_gated_nearest_match_top: gated nearest track match per detection
// load: taken in idle without leaving it. detection: one stored track compared
// per cycle through the single read port of the track ram, then a decide state.
// finish: steps through the stored tracks and can be held by an output stall.
// synchronous reset clears gates to 256, counters and used flags; ram is not
// cleared, only entries below track_count are ever read.
// ----------------------------------------------------------------------------
module greedy_gated_nearest_match_top
  import ggnm_pkg::*;
#(
  parameter int MAX_TRACKS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  // input stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // [19:0] pos_x, [39:20] pos_y
  input  logic [1:0]            s_tuser,   // [1:0] req_type
  // result stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // [5:0] trk_idx, [13:6] det_idx, zero pad
  output logic [1:0]            m_tuser,   // [1:0] result_kind
  output logic                  m_tlast,   // last
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [GATE_W-1:0]     cfg_data
);

  localparam int AW = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
  localparam int CW = $clog2(MAX_TRACKS + 1);

  state_t state, state_next;

  logic [GATE_W-1:0]    x_gate, y_gate;
  logic [CW-1:0]        track_count;
  logic [DET_W-1:0]     det_count;
  logic [MAX_TRACKS-1:0] used;

  logic [CW-1:0]        scan_idx;
  logic                 pipe_vld;
  logic [AW-1:0]        pipe_idx;
  logic                 found;
  logic [MAG_W-1:0]     best;
  logic [AW-1:0]        best_idx;
  logic [POS_W-1:0]     det_x, det_y;
  logic                 pend_vld;
  logic [AW-1:0]        pend_idx;

  logic [1:0]           out_kind;
  logic [TRK_W-1:0]     out_trk;
  logic [DET_W-1:0]     out_det;
  logic                 out_last;
  logic [TRK_W-1:0]     m_trk;
  logic [DET_W-1:0]     m_det;

  logic                 acc, out_free, load_ok;
  logic                 issue, out_load, det_done, mark_used;
  logic                 fin_adv, pend_take, frame_clear;
  logic                 at_end, cur_unused, cand, better;

  logic [2*POS_W-1:0]   rd_data;
  logic [POS_W-1:0]     tx, ty;
  logic [MAG_W-1:0]     dx_s, dy_s, dx, dy;

  assign cfg_ready = 1'b1;
  assign acc       = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign load_ok   = track_count < CW'(MAX_TRACKS);

  assign at_end     = scan_idx == track_count;
  assign cur_unused = !used[scan_idx[AW-1:0]];

  ggnm_ram #(
    .WIDTH (2*POS_W),
    .DEPTH (MAX_TRACKS)
  ) u_track_ram (
    .clk     (clk),
    .wr_en   (acc && (s_tuser == REQ_LOAD) && load_ok),
    .wr_addr (track_count[AW-1:0]),
    .wr_data (s_tdata[2*POS_W-1:0]),
    .rd_en   (issue),
    .rd_addr (scan_idx[AW-1:0]),
    .rd_data (rd_data)
  );

  // distance unit, one stored track per cycle
  assign tx   = rd_data[POS_W-1:0];
  assign ty   = rd_data[2*POS_W-1:POS_W];
  assign dx_s = {det_x[POS_W-1], det_x} - {tx[POS_W-1], tx};
  assign dy_s = {det_y[POS_W-1], det_y} - {ty[POS_W-1], ty};
  assign dx   = dx_s[MAG_W-1] ? (~dx_s + 1'b1) : dx_s;
  assign dy   = dy_s[MAG_W-1] ? (~dy_s + 1'b1) : dy_s;
  assign cand   = pipe_vld && !used[pipe_idx] && (dy < MAG_W'(y_gate));
  // strict compare keeps the earliest of equal candidates
  assign better = cand && (!found || (dx < best));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (acc && (s_tuser == REQ_DETECT)) begin
          state_next = ST_SCAN;
        end else if (acc && (s_tuser == REQ_FINISH)) begin
          state_next = ST_FINISH;
        end
      end
      ST_SCAN: begin
        if (!issue && !pipe_vld) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_FINISH: begin
        if (frame_clear) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_tready    = 1'b0;
    issue       = 1'b0;
    out_load    = 1'b0;
    det_done    = 1'b0;
    mark_used   = 1'b0;
    fin_adv     = 1'b0;
    pend_take   = 1'b0;
    frame_clear = 1'b0;
    out_kind    = KIND_MATCH;
    out_trk     = '0;
    out_det     = '0;
    out_last    = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
      end
      ST_SCAN: begin
        issue = !at_end;
      end
      ST_DECIDE: begin
        if (out_free) begin
          out_load = 1'b1;
          det_done = 1'b1;
          out_det  = det_count;
          out_last = 1'b1;
          if (found && (best < MAG_W'(x_gate))) begin
            mark_used = 1'b1;
            out_kind  = KIND_MATCH;
            out_trk   = TRK_W'(best_idx);
          end else begin
            out_kind  = KIND_UNMATCHED;
          end
        end
      end
      ST_FINISH: begin
        // an unused track is held back until the next one shows whether it is last
        out_kind = KIND_UNASSIGNED;
        out_trk  = TRK_W'(pend_idx);
        if (!at_end) begin
          if (!cur_unused) begin
            fin_adv = 1'b1;
          end else if (!pend_vld || out_free) begin
            fin_adv   = 1'b1;
            pend_take = 1'b1;
            out_load  = pend_vld;
          end
        end else if (!pend_vld) begin
          frame_clear = 1'b1;
        end else if (out_free) begin
          out_load    = 1'b1;
          out_last    = 1'b1;
          frame_clear = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      x_gate      <= GATE_RESET;
      y_gate      <= GATE_RESET;
      track_count <= '0;
      det_count   <= '0;
      used        <= '0;
      scan_idx    <= '0;
      pipe_vld    <= 1'b0;
      found       <= 1'b0;
      pend_vld    <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      state    <= state_next;
      pipe_vld <= issue;

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_X_GATE: x_gate <= cfg_data;
          CFG_Y_GATE: y_gate <= cfg_data;
          default: ;
        endcase
      end

      if (acc && (s_tuser == REQ_LOAD) && load_ok) begin
        used[track_count[AW-1:0]] <= 1'b0;
        track_count               <= track_count + 1'b1;
      end

      if (acc && ((s_tuser == REQ_DETECT) || (s_tuser == REQ_FINISH))) begin
        scan_idx <= '0;
        found    <= 1'b0;
        pend_vld <= 1'b0;
      end

      if (issue || fin_adv) begin
        scan_idx <= scan_idx + 1'b1;
      end

      if (better) begin
        found <= 1'b1;
      end

      if (mark_used) begin
        used[best_idx] <= 1'b1;
      end

      if (det_done && (det_count != DET_MAX)) begin
        det_count <= det_count + 1'b1;
      end

      if (pend_take) begin
        pend_vld <= 1'b1;
      end

      if (frame_clear) begin
        used        <= '0;
        track_count <= '0;
        det_count   <= '0;
        pend_vld    <= 1'b0;
      end

      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (acc && (s_tuser == REQ_DETECT)) begin
      det_x <= s_tdata[POS_W-1:0];
      det_y <= s_tdata[2*POS_W-1:POS_W];
    end
    pipe_idx <= scan_idx[AW-1:0];
    if (better) begin
      best     <= dx;
      best_idx <= pipe_idx;
    end
    if (pend_take) begin
      pend_idx <= scan_idx[AW-1:0];
    end
    if (out_load) begin
      m_tuser <= out_kind;
      m_trk   <= out_trk;
      m_det   <= out_det;
      m_tlast <= out_last;
    end
  end

  assign m_tdata = {(OUT_DATA_W - TRK_W - DET_W)'(0), m_det, m_trk};

endmodule

// ----- rtl/core/ggnm_checker.sv -----
// ----------------------------------------------------------------------------
// ggnm_checker
// port level checks on the nearest match block, bound to the top level
// ----------------------------------------------------------------------------
`include "greedy_gated_nearest_match_top_macros.svh"

module ggnm_checker
  import ggnm_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic [1:0]            s_tuser,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic [1:0]            m_tuser,
  input logic                  m_tlast
);

  logic s_acc;
  assign s_acc = s_tvalid && s_tready;

  // a held result stays offered
  `GGNM_ASSERT_NXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")

  // a detection occupies the block for its scan
  `GGNM_ASSERT_NXT(a_detect_busy, clk, rst, s_acc && (s_tuser == REQ_DETECT), !s_tready, "ready right after a detection")

  // loads never stall the input
  `GGNM_ASSERT_NXT(a_load_ready, clk, rst, s_acc && (s_tuser == REQ_LOAD), s_tready, "not ready after a load")

  // unmatched results carry no track, unassigned results carry no detection
  `GGNM_ASSERT_IMP(a_unmatched_trk, clk, rst, m_tvalid && (m_tuser == KIND_UNMATCHED), (m_tdata[5:0] == 6'd0) && m_tlast, "bad unmatched result")
  `GGNM_ASSERT_IMP(a_unassigned_det, clk, rst, m_tvalid && (m_tuser == KIND_UNASSIGNED), m_tdata[13:6] == 8'd0, "bad unassigned result")

endmodule

bind greedy_gated_nearest_match_top ggnm_checker u_ggnm_checker (.*);

// ----- sim/tb_greedy_gated_nearest_match_top.sv -----
// ----------------------------------------------------------------------------
// tb_greedy_gated_nearest_match_top
// drives track loads, detections and frame finishes into the nearest match
// block under random stalls on both streams, predicts every match, unmatched
// detection and unassigned track in step with the input, and compares the
// result stream field by field in order
// ----------------------------------------------------------------------------
module tb_greedy_gated_nearest_match_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ggnm_pkg::*;

  localparam int TRACK_SLOTS = 32;
  localparam int IDLE_PCT    = 38;

  localparam logic [1:0]           REQ_SPARE = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam logic [GATE_W-1:0]    GATE_MAX  = '1;

  typedef logic signed [POS_W-1:0] pos_t;

  localparam pos_t POS_MIN = -20'sd524288;
  localparam pos_t POS_MAX = 20'sd524287;

  typedef struct packed {
    logic [1:0]       kind;
    logic [TRK_W-1:0] trk;
    logic [DET_W-1:0] det;
    logic             last;
  } assoc_result_t;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic [1:0]            s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [1:0]            m_tuser;
  logic                  m_tlast;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [GATE_W-1:0]     cfg_data;

  // predicted block state
  pos_t              trk_x [TRACK_SLOTS];
  pos_t              trk_y [TRACK_SLOTS];
  bit                trk_used [TRACK_SLOTS];
  int                trk_count;
  int                det_count;
  logic [GATE_W-1:0] x_gate;
  logic [GATE_W-1:0] y_gate;

  assoc_result_t awaited[$];
  int            errors;
  int            items_sent;
  int            kind_seen [3];
  bit            steady;

  greedy_gated_nearest_match_top #(
    .MAX_TRACKS(TRACK_SLOTS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int abs_diff(pos_t a, pos_t b);
    int d;
    d = int'(a) - int'(b);
    return (d < 0) ? -d : d;
  endfunction

  function automatic pos_t clamp_pos(int v);
    if (v > int'(POS_MAX)) return POS_MAX;
    if (v < int'(POS_MIN)) return POS_MIN;
    return pos_t'(v);
  endfunction

  // offset that straddles the gate edge, kept small for wide gates
  function automatic int gate_offset(logic [GATE_W-1:0] g);
    int span;
    span = (g > 3000) ? 3000 : int'(g) + 2;
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  task automatic associate(input logic [1:0] req, input pos_t px, input pos_t py);
    int            best_dx;
    int            best_j;
    int            dx;
    int            dy;
    int            last_free;
    bit            found;
    assoc_result_t r;
    case (req)
      REQ_LOAD: begin
        if (trk_count < TRACK_SLOTS) begin
          trk_x[trk_count]    = px;
          trk_y[trk_count]    = py;
          trk_used[trk_count] = 1'b0;
          trk_count++;
        end
      end
      REQ_DETECT: begin
        found   = 1'b0;
        best_dx = 0;
        best_j  = 0;
        for (int j = 0; j < trk_count; j++) begin
          if (trk_used[j]) continue;
          dx = abs_diff(px, trk_x[j]);
          dy = abs_diff(py, trk_y[j]);
          // strict compare keeps the first of equal candidates
          if (dy < int'(y_gate) && (!found || dx < best_dx)) begin
            found   = 1'b1;
            best_dx = dx;
            best_j  = j;
          end
        end
        r.det  = DET_W'(det_count);
        r.last = 1'b1;
        if (det_count < 255) det_count++;
        if (found && best_dx < int'(x_gate)) begin
          trk_used[best_j] = 1'b1;
          r.kind = KIND_MATCH;
          r.trk  = TRK_W'(best_j);
        end else begin
          r.kind = KIND_UNMATCHED;
          r.trk  = '0;
        end
        awaited = {awaited, r};
      end
      REQ_FINISH: begin
        last_free = -1;
        for (int m = 0; m < trk_count; m++)
          if (!trk_used[m]) last_free = m;
        for (int m = 0; m < trk_count; m++) begin
          if (!trk_used[m]) begin
            r.kind = KIND_UNASSIGNED;
            r.trk  = TRK_W'(m);
            r.det  = '0;
            r.last = (m == last_free);
            awaited = {awaited, r};
          end
        end
        for (int m = 0; m < TRACK_SLOTS; m++) trk_used[m] = 1'b0;
        trk_count = 0;
        det_count = 0;
      end
      default: ;
    endcase
  endtask

  task automatic send_item(input logic [1:0] req, input pos_t px, input pos_t py);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= {py, px};
    do @(posedge clk); while (!s_tready);
    associate(req, px, py);
    items_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GATE_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_X_GATE: x_gate = val;
      CFG_Y_GATE: y_gate = val;
      default: ;
    endcase
  endtask

  task automatic set_gates(input logic [GATE_W-1:0] xg, input logic [GATE_W-1:0] yg);
    write_reg(CFG_X_GATE, xg);
    write_reg(CFG_Y_GATE, yg);
    cfg_valid <= 1'b0;
  endtask

  // wait for all results, then let a finish pass clear
  task automatic settle();
    s_tvalid <= 1'b0;
    while (awaited.size() != 0) @(posedge clk);
    repeat (TRACK_SLOTS + 8) @(posedge clk);
  endtask

  task automatic test_default_gates();
    send_item(REQ_FINISH, 20'sd0, 20'sd0);        // empty table, no result
    send_item(REQ_DETECT, 20'sd5, 20'sd5);        // empty table, unmatched
    send_item(REQ_LOAD, 20'sd0, 20'sd0);
    send_item(REQ_LOAD, 20'sd100, 20'sd0);
    send_item(REQ_LOAD, 20'sd100, 20'sd0);        // duplicate, tie with the one before
    send_item(REQ_LOAD, POS_MIN, POS_MAX);
    send_item(REQ_LOAD, POS_MAX, POS_MIN);
    send_item(REQ_DETECT, 20'sd100, 20'sd0);      // tie, first wins
    send_item(REQ_DETECT, 20'sd100, 20'sd0);      // second of the tie
    send_item(REQ_DETECT, 20'sd0, 20'sd256);      // dy on the gate, no candidate
    send_item(REQ_DETECT, 20'sd255, 20'sd255);    // just inside both gates
    send_item(REQ_DETECT, POS_MIN, POS_MAX);
    send_item(REQ_SPARE, -20'sd1, -20'sd1);       // ignored request code
    send_item(REQ_DETECT, POS_MAX - 20'sd256, POS_MIN); // candidate fails x gate
    send_item(REQ_FINISH, -20'sd1, -20'sd1);
    settle();
  endtask

  task automatic test_wide_gates();
    write_reg(CFG_SPARE, GATE_MAX);
    write_reg(CFG_X_GATE, GATE_MAX);
    write_reg(CFG_Y_GATE, GATE_MAX);
    cfg_valid <= 1'b0;
    send_item(REQ_LOAD, POS_MIN, 20'sd0);
    send_item(REQ_DETECT, POS_MAX, 20'sd0);       // widest distance
    send_item(REQ_DETECT, 20'sd0, 20'sd0);
    send_item(REQ_DETECT, -20'sd1, 20'sd0);       // dx equals the gate
    send_item(REQ_DETECT, -20'sd2, 20'sd0);
    send_item(REQ_FINISH, 20'sd0, 20'sd0);        // all used, no result
    settle();
  endtask

  task automatic test_closed_gates();
    set_gates('0, '0);
    send_item(REQ_LOAD, 20'sd0, 20'sd0);
    send_item(REQ_DETECT, 20'sd0, 20'sd0);
    send_item(REQ_FINISH, 20'sd0, 20'sd0);
    settle();
  endtask

  task automatic test_full_table();
    set_gates(GATE_RESET, GATE_RESET);
    for (int i = 0; i < TRACK_SLOTS; i++) send_item(REQ_LOAD, pos_t'(i * 1024), 20'sd0);
    send_item(REQ_LOAD, 20'sd100000, 20'sd100000); // table full, dropped
    send_item(REQ_DETECT, 20'sd100000, 20'sd100000);
    send_item(REQ_DETECT, pos_t'((TRACK_SLOTS - 1) * 1024), 20'sd0);
    send_item(REQ_FINISH, 20'sd0, 20'sd0);
    settle();
  endtask

  task automatic random_frame();
    int   n_load;
    int   n_det;
    int   pick;
    pos_t px;
    pos_t py;
    n_load = ($urandom_range(9) == 0) ? $urandom_range(20, TRACK_SLOTS + 2) :
                                         $urandom_range(0, 6);
    for (int i = 0; i < n_load; i++) begin
      if (trk_count > 0 && $urandom_range(7) == 0) begin
        px = trk_x[trk_count - 1];
        py = trk_y[trk_count - 1];
      end else begin
        px = pos_t'($urandom);
        py = pos_t'($urandom);
      end
      send_item(REQ_LOAD, px, py);
    end
    n_det = $urandom_range(1, n_load + 2);
    for (int i = 0; i < n_det; i++) begin
      case ($urandom_range(19))
        0: send_item(REQ_SPARE, pos_t'($urandom), pos_t'($urandom));
        1: send_item(REQ_LOAD, pos_t'($urandom), pos_t'($urandom));
        2, 3: send_item(REQ_DETECT, pos_t'($urandom), pos_t'($urandom));
        default: begin
          if (trk_count > 0) begin
            pick = $urandom_range(trk_count - 1);
            px = clamp_pos(int'(trk_x[pick]) + gate_offset(x_gate));
            py = clamp_pos(int'(trk_y[pick]) + gate_offset(y_gate));
          end else begin
            px = pos_t'($urandom);
            py = pos_t'($urandom);
          end
          send_item(REQ_DETECT, px, py);
        end
      endcase
    end
    // now and then the frame runs on into the next one
    if ($urandom_range(9) != 0) send_item(REQ_FINISH, pos_t'($urandom), pos_t'($urandom));
  endtask

  task automatic test_random_frames();
    int stop_at;
    int phase_end;
    stop_at = items_sent + 90;
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: set_gates(GATE_RESET, GATE_RESET);
        1: set_gates(GATE_W'(1), GATE_W'(1));
        2: set_gates(GATE_MAX, GATE_MAX);
        3: set_gates(GATE_W'($urandom_range(1, 2000)), GATE_W'($urandom_range(1, 2000)));
        4: set_gates('0, GATE_MAX);
        default: set_gates(GATE_MAX, '0);
      endcase
      steady = (p == 3);
      phase_end = items_sent + (stop_at - items_sent) / (6 - p);
      while (items_sent < phase_end) random_frame();
      send_item(REQ_FINISH, 20'sd0, 20'sd0);
      settle();
    end
    steady = 1'b0;
  endtask

  // result checker and output stall
  initial begin
    assoc_result_t e;
    logic [TRK_W-1:0] got_trk;
    logic [DET_W-1:0] got_det;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        got_trk = m_tdata[TRK_W-1:0];
        got_det = m_tdata[TRK_W +: DET_W];
        if (awaited.size() == 0) begin
          $error("result with nothing awaited: kind %0d track %0d detection %0d",
                 m_tuser, got_trk, got_det);
          errors++;
        end else begin
          e = awaited.pop_front();
          if (m_tuser != e.kind) begin
            $error("result_kind: expected %0d, got %0d", e.kind, m_tuser);
            errors++;
          end
          if (got_trk != e.trk) begin
            $error("trk_idx: expected %0d, got %0d", e.trk, got_trk);
            errors++;
          end
          if (got_det != e.det) begin
            $error("det_idx: expected %0d, got %0d", e.det, got_det);
            errors++;
          end
          if (m_tlast != e.last) begin
            $error("last: expected %0d, got %0d", e.last, m_tlast);
            errors++;
          end
          if (e.kind < 3) kind_seen[e.kind]++;
        end
      end
      m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  initial begin
    #(4_000_000);
    $display("tb_greedy_gated_nearest_match_top NOT OK");
    $finish;
  end

  initial begin
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= REQ_LOAD;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_X_GATE;
    cfg_data  <= '0;
    x_gate     = GATE_RESET;
    y_gate     = GATE_RESET;
    trk_count  = 0;
    det_count  = 0;
    errors     = 0;
    items_sent = 0;
    steady     = 1'b0;
    for (int m = 0; m < TRACK_SLOTS; m++) trk_used[m] = 1'b0;
    for (int k = 0; k < 3; k++) kind_seen[k] = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_default_gates();
    test_wide_gates();
    test_closed_gates();
    test_full_table();
    test_random_frames();

    $display("sent %0d items over gate settings from closed to fully open", items_sent);
    $display("checked %0d matches, %0d unmatched detections, %0d unassigned tracks",
             kind_seen[0], kind_seen[1], kind_seen[2]);
    if (errors == 0) begin
      $display("tb_greedy_gated_nearest_match_top OK");
    end else begin
      $display("tb_greedy_gated_nearest_match_top NOT OK");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/ggnm_pkg.sv
rtl/core/ggnm_ram.sv
rtl/core/greedy_gated_nearest_match_top.sv
rtl/core/ggnm_checker.sv
sim/tb_greedy_gated_nearest_match_top.sv
